// ----- rtl/core/flcc_pkg.sv -----
// shared types and constants for the framed line checksum checker
// depends on nothing; used by the top, flcc_front, flcc_back and the testbench
package flcc_pkg;

  localparam int LINE_BUFFER_BYTES = 256;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_NUL    = 8'h00;

  localparam logic [1:0] HEX_CHARS_MAX = 2'd2;
  localparam logic [2:0] ID_CHARS_MAX  = 3'd4;

  // one classified byte, as it travels from the front to the back
  typedef struct packed {
    logic       term;
    logic       nul;
    logic       dollar;
    logic       star;
    logic       comma;
    logic       hex_ok;
    logic [3:0] hex_digit;
    logic       dec_ok;
    logic [3:0] dec_digit;
    logic [7:0] data;
  } beat_t;

  // one result beat
  typedef struct packed {
    logic        checksum_ok;
    logic [13:0] message_id;
    logic [31:0] lines_received;
    logic [31:0] lines_valid;
    logic [31:0] lines_invalid;
  } result_t;

endpackage

// ----- rtl/core/framed_line_checksum_checker_top.sv -----
// top level of the framed line checksum checker
// depends on flcc_pkg, flcc_front, flcc_queue and flcc_back
//
// usage:
//   input side is a queue write port: drive rx_byte and push; a beat is
//   taken at a clock edge with push high and full low
//   result side is a queue read port: while empty is low the oldest result
//   sits on checksum_ok, message_id and the three line counters; it leaves
//   at a clock edge with pop high and empty low
//   one result follows each cr or lf that closes a non-empty line; other
//   bytes and empty lines give none, and an overflow drops the line so far
// a terminator is held in the byte queue and its result in the result queue
// throughput: one byte per cycle while full is low; the line parser updates
//   all its state for each byte that it takes
// stall: a two-beat byte queue sits between the classifier and the parser,
//   and a two-beat result queue sits behind the parser; when results are
//   not popped the parser holds at a terminator once the result queue is full,
//   and full rises once the byte queue fills
// reset: rst is synchronous; it empties both queues, clears the current
//   line and zeroes the three counters
module framed_line_checksum_checker_top #(
  parameter int LINE_BUFFER_BYTES = flcc_pkg::LINE_BUFFER_BYTES,
  parameter int QUEUE_DEPTH       = flcc_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic        checksum_ok,
  output logic [13:0] message_id,
  output logic [31:0] lines_received,
  output logic [31:0] lines_valid,
  output logic [31:0] lines_invalid
);

  localparam int BW = $bits(flcc_pkg::beat_t);
  localparam int RW = $bits(flcc_pkg::result_t);

  flcc_pkg::beat_t   front_beat;
  flcc_pkg::beat_t   head_beat;
  flcc_pkg::result_t back_res;
  flcc_pkg::result_t out_res;
  logic              front_push;
  logic              byte_empty;
  logic              beat_pop;
  logic              res_push;
  logic              res_full;
  logic [BW-1:0]     head_bits;
  logic [RW-1:0]     out_bits;

  flcc_front u_front (
    .push      (push),
    .rx_byte   (rx_byte),
    .beat_push (front_push),
    .beat      (front_beat)
  );

  flcc_queue #(
    .WIDTH (BW),
    .DEPTH (QUEUE_DEPTH)
  ) u_byte_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .wdata (front_beat),
    .full  (full),
    .pop   (beat_pop),
    .rdata (head_bits),
    .empty (byte_empty)
  );

  assign head_beat = flcc_pkg::beat_t'(head_bits);

  flcc_back #(
    .LINE_BUFFER_BYTES (LINE_BUFFER_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (!byte_empty),
    .beat       (head_beat),
    .beat_pop   (beat_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (back_res)
  );

  flcc_queue #(
    .WIDTH (RW),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_bits),
    .empty (empty)
  );

  assign out_res        = flcc_pkg::result_t'(out_bits);
  assign checksum_ok    = out_res.checksum_ok;
  assign message_id     = out_res.message_id;
  assign lines_received = out_res.lines_received;
  assign lines_valid    = out_res.lines_valid;
  assign lines_invalid  = out_res.lines_invalid;

endmodule

// ----- rtl/core/flcc_queue.sv -----
// small first-in first-out register queue with show-ahead head
// depends on nothing; used for both the byte and the result queues
module flcc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/flcc_front.sv -----
// front end: takes received bytes and classifies each one
// depends on flcc_pkg; feeds the byte queue
module flcc_front (
  input  logic          push,
  input  logic [7:0]    rx_byte,
  output logic          beat_push,
  output flcc_pkg::beat_t beat
);

  logic [7:0] hex_sub;

  assign beat_push = push;

  always_comb begin
    hex_sub        = 8'd0;
    beat           = '0;
    beat.data      = rx_byte;
    beat.term      = (rx_byte == flcc_pkg::CHAR_LF) || (rx_byte == flcc_pkg::CHAR_CR);
    beat.nul       = (rx_byte == flcc_pkg::CHAR_NUL);
    beat.dollar    = (rx_byte == flcc_pkg::CHAR_DOLLAR);
    beat.star      = (rx_byte == flcc_pkg::CHAR_STAR);
    beat.comma     = (rx_byte == flcc_pkg::CHAR_COMMA);
    beat.dec_ok    = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
    beat.dec_digit = rx_byte[3:0];
    if ((rx_byte >= 8'h30) && (rx_byte <= 8'h39)) begin
      beat.hex_ok = 1'b1;
      hex_sub     = rx_byte - 8'h30;
    end else if ((rx_byte >= 8'h41) && (rx_byte <= 8'h46)) begin
      beat.hex_ok = 1'b1;
      hex_sub     = rx_byte - 8'd55;
    end else if ((rx_byte >= 8'h61) && (rx_byte <= 8'h66)) begin
      beat.hex_ok = 1'b1;
      hex_sub     = rx_byte - 8'd87;
    end
    beat.hex_digit = hex_sub[3:0];
  end

endmodule

// ----- rtl/core/flcc_back.sv -----
// back end: line parser, checksum compare, id decode and line counters
// depends on flcc_pkg; reads the byte queue and writes the result queue
module flcc_back #(
  parameter int LINE_BUFFER_BYTES = flcc_pkg::LINE_BUFFER_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              beat_valid,
  input  flcc_pkg::beat_t   beat,
  output logic              beat_pop,
  input  logic              res_full,
  output logic              res_push,
  output flcc_pkg::result_t res
);

  localparam int LW = $clog2(LINE_BUFFER_BYTES);

  logic [LW-1:0] line_length,     line_length_next;
  logic          first_is_dollar, first_is_dollar_next;
  logic          content_ended,   content_ended_next;
  logic          star_seen,       star_seen_next;
  logic [7:0]    body_xor,        body_xor_next;
  logic [1:0]    hex_chars_taken, hex_chars_taken_next;
  logic [7:0]    hex_value,       hex_value_next;
  logic          hex_stopped,     hex_stopped_next;
  logic          comma_seen,      comma_seen_next;
  logic [2:0]    id_chars_taken,  id_chars_taken_next;
  logic [13:0]   id_value,        id_value_next;
  logic          id_stopped,      id_stopped_next;
  logic [31:0]   received_total,  received_total_next;
  logic [31:0]   valid_total,     valid_total_next;
  logic [31:0]   invalid_total,   invalid_total_next;

  logic wants_result;
  logic ok;
  logic clear;

  assign wants_result = beat_valid && beat.term && (line_length != '0);
  assign beat_pop     = beat_valid && !(wants_result && res_full);
  assign ok           = first_is_dollar && star_seen && (body_xor == hex_value);

  always_comb begin
    line_length_next     = line_length;
    first_is_dollar_next = first_is_dollar;
    content_ended_next   = content_ended;
    star_seen_next       = star_seen;
    body_xor_next        = body_xor;
    hex_chars_taken_next = hex_chars_taken;
    hex_value_next       = hex_value;
    hex_stopped_next     = hex_stopped;
    comma_seen_next      = comma_seen;
    id_chars_taken_next  = id_chars_taken;
    id_value_next        = id_value;
    id_stopped_next      = id_stopped;
    received_total_next  = received_total;
    valid_total_next     = valid_total;
    invalid_total_next   = invalid_total;
    clear                = 1'b0;
    res_push             = 1'b0;

    if (beat_pop) begin
      if (beat.term) begin
        if (line_length != '0) begin
          res_push            = 1'b1;
          clear               = 1'b1;
          received_total_next = received_total + 32'd1;
          if (ok) begin
            valid_total_next = valid_total + 32'd1;
          end else begin
            invalid_total_next = invalid_total + 32'd1;
          end
        end
      end else if (line_length < LW'(LINE_BUFFER_BYTES - 1)) begin
        line_length_next = line_length + 1'b1;
        if (beat.nul) begin
          content_ended_next = 1'b1;
        end else if (!content_ended) begin
          if (line_length == '0) begin
            first_is_dollar_next = beat.dollar;
          end
          // checksum side
          if (star_seen) begin
            if (hex_chars_taken < flcc_pkg::HEX_CHARS_MAX) begin
              hex_chars_taken_next = hex_chars_taken + 2'd1;
              if (!hex_stopped) begin
                if (beat.hex_ok) begin
                  hex_value_next = {hex_value[3:0], beat.hex_digit};
                end else begin
                  hex_stopped_next = 1'b1;
                end
              end
            end
          end else if (beat.star) begin
            star_seen_next = 1'b1;
          end else if (line_length != '0) begin
            body_xor_next = body_xor ^ beat.data;
          end
          // id side, at most four digits so the value stays below 10000
          if (comma_seen) begin
            if (id_chars_taken < flcc_pkg::ID_CHARS_MAX) begin
              id_chars_taken_next = id_chars_taken + 3'd1;
              if (!id_stopped) begin
                if (beat.dec_ok) begin
                  id_value_next = (id_value << 3) + (id_value << 1) + {10'd0, beat.dec_digit};
                end else begin
                  id_stopped_next = 1'b1;
                end
              end
            end
          end else if (beat.comma) begin
            comma_seen_next = 1'b1;
          end
        end
      end else begin
        // overflow drops the line received so far; later bytes start a new line
        clear = 1'b1;
      end
    end

    if (clear) begin
      line_length_next     = '0;
      first_is_dollar_next = 1'b0;
      content_ended_next   = 1'b0;
      star_seen_next       = 1'b0;
      body_xor_next        = 8'd0;
      hex_chars_taken_next = 2'd0;
      hex_value_next       = 8'd0;
      hex_stopped_next     = 1'b0;
      comma_seen_next      = 1'b0;
      id_chars_taken_next  = 3'd0;
      id_value_next        = 14'd0;
      id_stopped_next      = 1'b0;
    end
  end

  always_comb begin
    res.checksum_ok    = ok;
    res.message_id     = id_value;
    res.lines_received = received_total_next;
    res.lines_valid    = valid_total_next;
    res.lines_invalid  = invalid_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length     <= '0;
      first_is_dollar <= 1'b0;
      content_ended   <= 1'b0;
      star_seen       <= 1'b0;
      body_xor        <= 8'd0;
      hex_chars_taken <= 2'd0;
      hex_value       <= 8'd0;
      hex_stopped     <= 1'b0;
      comma_seen      <= 1'b0;
      id_chars_taken  <= 3'd0;
      id_value        <= 14'd0;
      id_stopped      <= 1'b0;
      received_total  <= 32'd0;
      valid_total     <= 32'd0;
      invalid_total   <= 32'd0;
    end else begin
      line_length     <= line_length_next;
      first_is_dollar <= first_is_dollar_next;
      content_ended   <= content_ended_next;
      star_seen       <= star_seen_next;
      body_xor        <= body_xor_next;
      hex_chars_taken <= hex_chars_taken_next;
      hex_value       <= hex_value_next;
      hex_stopped     <= hex_stopped_next;
      comma_seen      <= comma_seen_next;
      id_chars_taken  <= id_chars_taken_next;
      id_value        <= id_value_next;
      id_stopped      <= id_stopped_next;
      received_total  <= received_total_next;
      valid_total     <= valid_total_next;
      invalid_total   <= invalid_total_next;
    end
  end

endmodule

// ----- test/tb_top.sv -----
// self-checking testbench for framed_line_checksum_checker_top
// feeds a directed byte table and then random sentences; every line result is checked
// against the table or an in-bench line parser; depends on flcc_pkg and the block's rtl
`timescale 1ns / 1ps

module tb_top;
  import flcc_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int ITEM_TARGET    = 1550;
  localparam int TAIL_ITEMS     = 150;
  localparam int HOLD_OFF_AT    = 500;
  localparam int HOLD_CYCLES    = 300;
  localparam int FULL_LINE_AT   = 400;
  localparam int OVERFLOW_AT    = 900;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [7:0] DIGIT_ZERO   = 8'h30;
  localparam logic [7:0] DIGIT_NINE   = 8'h39;
  localparam logic [7:0] UPPER_A      = 8'h41;
  localparam logic [7:0] UPPER_F      = 8'h46;
  localparam logic [7:0] LOWER_A      = 8'h61;
  localparam logic [7:0] LOWER_F      = 8'h66;
  localparam logic [7:0] PRINT_LOW    = 8'h20;
  localparam logic [7:0] PRINT_HIGH   = 8'h7E;
  localparam logic [7:0] FILLER_CHAR  = 8'h23;

  typedef struct packed {
    logic [7:0] data;
    logic       typed;
    result_t    res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  rx_byte;
  logic        empty;
  logic        pop;
  logic        checksum_ok;
  logic [13:0] message_id;
  logic [31:0] lines_received;
  logic [31:0] lines_valid;
  logic [31:0] lines_invalid;

  // line parser state
  int unsigned ln_len;
  logic        ln_dollar;
  logic        ln_ended;
  logic        ln_star;
  logic [7:0]  ln_xor;
  logic [1:0]  ln_hex_taken;
  logic [7:0]  ln_hex;
  logic        ln_hex_stop;
  logic        ln_comma;
  logic [2:0]  ln_id_taken;
  logic [13:0] ln_id;
  logic        ln_id_stop;
  logic [31:0] tot_received;
  logic [31:0] tot_valid;
  logic [31:0] tot_invalid;

  result_t     awaited_lines[$];
  logic [7:0]  frame_bytes[$];
  int          bytes_sent    = 0;
  int          failures      = 0;
  int          send_idle_pct = 15;
  bit          tail_quiet    = 1'b0;
  bit          hold_request  = 1'b0;
  bit          hold_done     = 1'b0;
  int unsigned quiet_cycles  = 0;

  framed_line_checksum_checker_top dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .rx_byte        (rx_byte),
    .empty          (empty),
    .pop            (pop),
    .checksum_ok    (checksum_ok),
    .message_id     (message_id),
    .lines_received (lines_received),
    .lines_valid    (lines_valid),
    .lines_invalid  (lines_invalid)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void clear_line();
    ln_len       = 0;
    ln_dollar    = 1'b0;
    ln_ended     = 1'b0;
    ln_star      = 1'b0;
    ln_xor       = '0;
    ln_hex_taken = '0;
    ln_hex       = '0;
    ln_hex_stop  = 1'b0;
    ln_comma     = 1'b0;
    ln_id_taken  = '0;
    ln_id        = '0;
    ln_id_stop   = 1'b0;
  endfunction

  task automatic parse_byte(input logic [7:0] b, output bit produced, output result_t res);
    bit         ok;
    bit         is_hex;
    logic [3:0] nib;
    produced = 1'b0;
    res      = '0;
    if (b == CHAR_LF || b == CHAR_CR) begin
      if (ln_len != 0) begin
        ok = ln_dollar && ln_star && (ln_xor == ln_hex);
        tot_received++;
        if (ok) tot_valid++;
        else tot_invalid++;
        res.checksum_ok    = ok;
        res.message_id     = ln_id;
        res.lines_received = tot_received;
        res.lines_valid    = tot_valid;
        res.lines_invalid  = tot_invalid;
        produced = 1'b1;
        clear_line();
      end
    end else if (ln_len < LINE_BUFFER_BYTES - 1) begin
      if (b == CHAR_NUL) begin
        ln_ended = 1'b1;
      end else if (!ln_ended) begin
        is_hex = 1'b1;
        nib    = '0;
        if (b >= DIGIT_ZERO && b <= DIGIT_NINE) nib = 4'(b - DIGIT_ZERO);
        else if (b >= UPPER_A && b <= UPPER_F) nib = 4'(b - UPPER_A + 8'd10);
        else if (b >= LOWER_A && b <= LOWER_F) nib = 4'(b - LOWER_A + 8'd10);
        else is_hex = 1'b0;
        if (ln_len == 0) ln_dollar = (b == CHAR_DOLLAR);
        // checksum side
        if (ln_star) begin
          if (ln_hex_taken < HEX_CHARS_MAX) begin
            ln_hex_taken++;
            if (!ln_hex_stop) begin
              if (is_hex) ln_hex = {ln_hex[3:0], nib};
              else ln_hex_stop = 1'b1;
            end
          end
        end else if (b == CHAR_STAR) begin
          ln_star = 1'b1;
        end else if (ln_len >= 1) begin
          ln_xor ^= b;
        end
        // id side, independent of the checksum side
        if (ln_comma) begin
          if (ln_id_taken < ID_CHARS_MAX) begin
            ln_id_taken++;
            if (!ln_id_stop) begin
              if (b >= DIGIT_ZERO && b <= DIGIT_NINE)
                ln_id = 14'((int'(ln_id) * 10 + int'(b - DIGIT_ZERO)) % 10000);
              else ln_id_stop = 1'b1;
            end
          end
        end else if (b == CHAR_COMMA) begin
          ln_comma = 1'b1;
        end
      end
      ln_len++;
    end else begin
      clear_line();
    end
  endtask

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 3))
      0, 1:    return 0;
      2:       return 15;
      default: return 35;
    endcase
  endfunction

  function automatic stim_row_t row_plain(logic [7:0] d);
    stim_row_t r;
    r       = '0;
    r.data  = d;
    return r;
  endfunction

  function automatic stim_row_t row_closing(logic [7:0] d, logic ok, int id, int rcv, int vld,
                                            int inv);
    stim_row_t r;
    r                    = '0;
    r.data               = d;
    r.typed              = 1'b1;
    r.res.checksum_ok    = ok;
    r.res.message_id     = 14'(id);
    r.res.lines_received = 32'(rcv);
    r.res.lines_valid    = 32'(vld);
    r.res.lines_invalid  = 32'(inv);
    return r;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    if (nib < 4'd10) return DIGIT_ZERO + 8'(nib);
    return ($urandom_range(0, 1) ? UPPER_A : LOWER_A) + 8'(nib) - 8'd10;
  endfunction

  // '$' body '*' checksum terminator, appended to frame_bytes
  function automatic void build_sentence(int body_len, bit good_sum);
    logic [7:0] sum;
    logic [7:0] c;
    int         comma_at;
    int         digits;
    sum      = '0;
    comma_at = $urandom_range(0, 1) ? int'($urandom_range(0, body_len)) : -1;
    digits   = $urandom_range(0, 6);
    frame_bytes.push_back(CHAR_DOLLAR);
    for (int i = 0; i < body_len; i++) begin
      if (i == comma_at) begin
        c = CHAR_COMMA;
      end else if (comma_at >= 0 && i > comma_at && i <= comma_at + digits) begin
        c = ($urandom_range(0, 2) == 0) ? DIGIT_NINE : DIGIT_ZERO + 8'($urandom_range(0, 9));
      end else begin
        c = 8'($urandom_range(PRINT_LOW, PRINT_HIGH));
        if (c == CHAR_STAR) c = FILLER_CHAR;
      end
      sum ^= c;
      frame_bytes.push_back(c);
    end
    frame_bytes.push_back(CHAR_STAR);
    if (good_sum) begin
      frame_bytes.push_back(hex_char(sum[7:4]));
      frame_bytes.push_back(hex_char(sum[3:0]));
    end else begin
      case ($urandom_range(0, 3))
        0: ;
        1: frame_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
        2: begin
          frame_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
          frame_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
        end
        default: begin
          // comma right after the star
          frame_bytes.push_back(CHAR_COMMA);
          frame_bytes.push_back(DIGIT_ZERO + 8'($urandom_range(0, 9)));
        end
      endcase
    end
    case ($urandom_range(0, 2))
      0:       frame_bytes.push_back(CHAR_LF);
      1:       frame_bytes.push_back(CHAR_CR);
      default: begin
        frame_bytes.push_back(CHAR_CR);
        frame_bytes.push_back(CHAR_LF);
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic typed, input result_t typed_res);
    bit      produced;
    result_t predicted;
    if (bytes_sent % 48 == 0) send_idle_pct = pick_idle_pct();
    if (!tail_quiet && $urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    push    <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
    parse_byte(b, produced, predicted);
    if (typed) awaited_lines.push_back(typed_res);
    else if (produced) awaited_lines.push_back(predicted);
  endtask

  task automatic check_line_result();
    result_t want;
    if (awaited_lines.size() == 0) begin
      $error("line result with no closed line waiting: message_id %0d", message_id);
      failures++;
    end else begin
      want = awaited_lines.pop_front();
      if (checksum_ok !== want.checksum_ok) begin
        $error("checksum_ok: expected %0d, got %0d", want.checksum_ok, checksum_ok);
        failures++;
      end
      if (message_id !== want.message_id) begin
        $error("message_id: expected %0d, got %0d", want.message_id, message_id);
        failures++;
      end
      if (lines_received !== want.lines_received) begin
        $error("lines_received: expected %0d, got %0d", want.lines_received, lines_received);
        failures++;
      end
      if (lines_valid !== want.lines_valid) begin
        $error("lines_valid: expected %0d, got %0d", want.lines_valid, lines_valid);
        failures++;
      end
      if (lines_invalid !== want.lines_invalid) begin
        $error("lines_invalid: expected %0d, got %0d", want.lines_invalid, lines_invalid);
        failures++;
      end
    end
  endtask

  // result side
  initial begin
    int stall_left;
    int pop_idle_pct;
    int cycle_no;
    stall_left   = 0;
    pop_idle_pct = 0;
    cycle_no     = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (pop && !empty) check_line_result();
      cycle_no++;
      if (cycle_no % 64 == 0) pop_idle_pct = pick_idle_pct();
      if (hold_request && !hold_done) begin
        // long hold-off so the block backs up to full
        hold_done = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        pop <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (!tail_quiet && $urandom_range(0, 99) < pop_idle_pct) begin
        stall_left = $urandom_range(0, 3);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[framed_line_checksum_checker_top] ERROR");
      $finish;
    end
  end

  initial begin
    stim_row_t directed_rows [24];
    int        kind;
    int        pos;
    int        star_at;
    bit        full_line_sent;
    bit        overflow_sent;
    full_line_sent = 1'b0;
    overflow_sent  = 1'b0;
    rst     <= 1'b1;
    push    <= 1'b0;
    rx_byte <= '0;
    clear_line();
    tot_received = '0;
    tot_valid    = '0;
    tot_invalid  = '0;
    directed_rows = '{
      // shortest valid sentence
      row_plain(CHAR_DOLLAR), row_plain(CHAR_STAR), row_plain("0"), row_plain("0"),
      row_closing(CHAR_LF, 1'b1, 0, 1, 1, 0),
      // empty line
      row_plain(CHAR_CR),
      // id after the comma, lower case checksum
      row_plain(CHAR_DOLLAR), row_plain("A"), row_plain(CHAR_COMMA), row_plain("1"),
      row_plain("2"), row_plain(CHAR_STAR), row_plain("6"), row_plain("e"),
      row_closing(CHAR_CR, 1'b1, 12, 2, 2, 0),
      // line opening with a zero byte
      row_plain(CHAR_NUL), row_plain(CHAR_DOLLAR),
      row_closing(CHAR_LF, 1'b0, 0, 3, 2, 1),
      row_plain(8'hFF),
      row_closing(CHAR_LF, 1'b0, 0, 4, 2, 2),
      // comma inside the checksum field
      row_plain(CHAR_STAR), row_plain(CHAR_COMMA), row_plain("9"),
      row_closing(CHAR_LF, 1'b0, 9, 5, 2, 3)
    };
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].res);

    while (bytes_sent < ITEM_TARGET) begin
      if (bytes_sent >= ITEM_TARGET - TAIL_ITEMS) tail_quiet = 1'b1;
      if (bytes_sent >= HOLD_OFF_AT) hold_request = 1'b1;
      frame_bytes.delete();
      if (!full_line_sent && bytes_sent >= FULL_LINE_AT) begin
        // exactly LINE_BUFFER_BYTES-1 content bytes
        build_sentence(LINE_BUFFER_BYTES - 5, 1'b1);
        full_line_sent = 1'b1;
      end else if (!overflow_sent && bytes_sent >= OVERFLOW_AT) begin
        build_sentence(LINE_BUFFER_BYTES + 2, 1'b1);
        overflow_sent = 1'b1;
      end else begin
        kind = $urandom_range(0, 99);
        if (kind < 65) begin
          build_sentence($urandom_range(0, 14), $urandom_range(0, 9) != 0);
        end else if (kind < 80) begin
          build_sentence($urandom_range(0, 14), 1'b1);
          pos = $urandom_range(0, frame_bytes.size() - 2);
          case ($urandom_range(0, 3))
            0: frame_bytes[pos] = 8'($urandom_range(0, 255));
            1: frame_bytes.delete(0);
            2: frame_bytes.insert(pos, CHAR_NUL);
            default: begin
              star_at = -1;
              foreach (frame_bytes[i])
                if (frame_bytes[i] == CHAR_STAR && star_at < 0) star_at = i;
              if (star_at >= 0) frame_bytes.delete(star_at);
            end
          endcase
        end else if (kind < 95) begin
          repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom_range(0, 255)));
          if ($urandom_range(0, 1)) frame_bytes.push_back(CHAR_LF);
        end else begin
          repeat ($urandom_range(1, 3))
            frame_bytes.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
        end
      end
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], 1'b0, '0);
    end
    push <= 1'b0;

    while (awaited_lines.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && awaited_lines.size() == 0) begin
      $display("[framed_line_checksum_checker_top] OK");
    end else begin
      $display("[framed_line_checksum_checker_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/flcc_pkg.sv
rtl/core/flcc_queue.sv
rtl/core/flcc_front.sv
rtl/core/flcc_back.sv
rtl/core/framed_line_checksum_checker_top.sv
test/tb_top.sv
